[hw/rtl/i2cme_pkg.sv]
// Package for the I2C master byte engine.
// Command codes, the per-tick line result type and counter helpers.
// No dependencies.
`default_nettype none

package i2cme_pkg;

    localparam int DELAY_COUNTER_BITS = 16;
    localparam int HALF_PERIOD_W      = 16;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = HALF_PERIOD_W'(120);

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_SEND_ACK   = 3'd5;
    localparam logic [OP_W-1:0] OP_SAMPLE_ACK = 3'd6;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       ack_seen;
        logic [7:0] received_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } t_line_res;

    // half period of zero acts as one; clamp to the counter range
    function automatic logic [DELAY_COUNTER_BITS-1:0] counter_load(
        input logic [HALF_PERIOD_W-1:0] hp
    );
        logic [HALF_PERIOD_W:0] v;
        logic [HALF_PERIOD_W:0] mask;
        v    = (hp == '0) ? '0 : ({1'b0, hp} - 1'b1);
        mask = (DELAY_COUNTER_BITS >= HALF_PERIOD_W + 1) ? '1
             : (HALF_PERIOD_W + 1)'((64'd1 << DELAY_COUNTER_BITS) - 64'd1);
        if (v > mask) begin
            v = mask;
        end
        return DELAY_COUNTER_BITS'(v);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/i2c_master_byte_engine.sv]
// I2C master byte engine top level: stream ports, input and result registers.
// Depends on i2cme_pkg and i2cme_core.
//
// Usage: every request on the slave stream is one tick of the bit timing
// clock. tuser carries the command code (0 none, 1 start, 2 stop, 3 write
// byte, 4 read byte, 5 send ack, 6 sample ack); tdata carries the byte to
// send, the ack level and the sampled SDA pin. Each request yields exactly
// one result request on the master stream with the line levels, SDA
// direction, busy, a one-tick done flag, the last received byte and the
// last sampled ack. Commands arriving while busy are dropped.
// A request is held in the input register, then the sequencer step writes
// the result register. Throughput: one request per cycle while the receiver
// takes results.
// Reset (synchronous, active low) empties both registers, idles the
// sequencer, drives SDA low and SCL low, and loads a half period of 120.
// When the receiver stalls, the result register holds and the input
// register fills; tready drops only when both are full.
// i_cfg_we writes the half period; write it only while idle.
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] data_byte, [8] ack_level, [9] sda_in, [15:10] zero
    input  wire logic [15:0] s_axis_tdata,
    // [2:0] operation
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
    // [4] done_res, [12:5] received_byte, [13] ack_seen, [15:14] zero
    output logic [15:0]      m_axis_tdata
);
    import i2cme_pkg::*;

    logic [HALF_PERIOD_W-1:0] r_half_period;
    logic                     r_in_valid;
    logic [OP_W-1:0]          r_op;
    logic [7:0]               r_data;
    logic                     r_ackl;
    logic                     r_sda_in;
    logic                     r_out_valid;
    t_line_res                r_out;
    t_line_res                step_res;
    logic                     advance;
    logic                     step;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= s_axis_tuser;
            r_data   <= s_axis_tdata[7:0];
            r_ackl   <= s_axis_tdata[8];
            r_sda_in <= s_axis_tdata[9];
        end
    end

    i2cme_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_operation   (r_op),
        .i_data_byte   (r_data),
        .i_ack_level   (r_ackl),
        .i_sda_in      (r_sda_in),
        .i_half_period (r_half_period),
        .o_res         (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.ack_seen, r_out.received_byte, r_out.done_res,
                            r_out.busy_res, r_out.sda_drive, r_out.sda_level,
                            r_out.scl_level};

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done result still reports busy");

    a_release_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.sda_drive |-> r_out.busy_res)
        else $error("SDA released while idle");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("sequencer step lost its result");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

[hw/rtl/i2cme_core.sv]
// Line sequencer of the I2C master byte engine: state registers and one tick step.
// Depends on i2cme_pkg.
`default_nettype none

module i2cme_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_step,
    input  wire logic [i2cme_pkg::OP_W-1:0]            i_operation,
    input  wire logic [7:0]                            i_data_byte,
    input  wire logic                                  i_ack_level,
    input  wire logic                                  i_sda_in,
    input  wire logic [i2cme_pkg::HALF_PERIOD_W-1:0]   i_half_period,
    output i2cme_pkg::t_line_res                       o_res
);
    import i2cme_pkg::*;

    logic [OP_W-1:0]               r_cmd, n_cmd;
    logic                          r_phase, n_phase;
    logic [1:0]                    r_start_ph, n_start_ph;
    logic [3:0]                    r_bit, n_bit;
    logic [DELAY_COUNTER_BITS-1:0] r_delay, n_delay;
    logic [7:0]                    r_shift, n_shift;
    logic [7:0]                    r_recv, n_recv;
    logic                          r_ack, n_ack;
    logic                          r_scl, n_scl;
    logic                          r_sda, n_sda;
    logic                          r_dir, n_dir;
    logic                          done;
    logic [DELAY_COUNTER_BITS-1:0] load;
    logic [3:0]                    bit_inc;

    assign load    = counter_load(i_half_period);
    assign bit_inc = r_bit + 4'd1;

    always_comb begin
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_start_ph = r_start_ph;
        n_bit      = r_bit;
        n_delay    = r_delay;
        n_shift    = r_shift;
        n_recv     = r_recv;
        n_ack      = r_ack;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_dir      = r_dir;
        done       = 1'b0;

        if (r_cmd != OP_NONE) begin
            if (r_delay != '0) begin
                n_delay = r_delay - 1'b1;
            end else begin
                unique case (r_cmd)
                    OP_START: begin
                        if (r_start_ph == 2'd0) begin
                            n_sda = 1'b0; n_start_ph = 2'd1; n_delay = load;
                        end else if (r_start_ph == 2'd1) begin
                            n_scl = 1'b0; n_start_ph = 2'd2; n_delay = load;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (!r_phase) begin
                            n_sda = 1'b1; n_phase = 1'b1; n_delay = load;
                        end else begin
                            n_scl = 1'b0; n_sda = 1'b0; done = 1'b1;
                        end
                    end
                    OP_WRITE: begin
                        if (!r_phase) begin
                            n_scl = 1'b0; n_phase = 1'b1; n_delay = load;
                        end else begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_sda = 1'b0; done = 1'b1;
                            end else begin
                                n_sda   = r_shift[6];
                                n_scl   = 1'b1;
                                n_phase = 1'b0;
                                n_delay = load;
                            end
                        end
                    end
                    OP_READ: begin
                        if (!r_phase) begin
                            n_shift = {r_shift[6:0], i_sda_in};
                            n_scl   = 1'b0;
                            n_phase = 1'b1;
                            n_delay = load;
                        end else begin
                            n_bit = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE) begin
                                n_dir  = 1'b1;
                                n_recv = r_shift;
                                done   = 1'b1;
                            end else begin
                                n_scl   = 1'b1;
                                n_phase = 1'b0;
                                n_delay = load;
                            end
                        end
                    end
                    OP_SEND_ACK: begin
                        n_scl = 1'b0; n_sda = 1'b0; done = 1'b1;
                    end
                    default: begin
                        n_ack = i_sda_in;
                        n_scl = 1'b0;
                        n_dir = 1'b1;
                        done  = 1'b1;
                    end
                endcase
                if (done) begin
                    n_cmd      = OP_NONE;
                    n_phase    = 1'b0;
                    n_start_ph = 2'd0;
                    n_bit      = '0;
                    n_delay    = '0;
                end
            end
        end else if (i_operation != OP_NONE && i_operation <= OP_SAMPLE_ACK) begin
            n_cmd      = i_operation;
            n_bit      = '0;
            n_phase    = 1'b0;
            n_start_ph = 2'd0;
            n_delay    = load;
            n_scl      = 1'b1;
            unique case (i_operation)
                OP_START:    begin n_dir = 1'b1; n_sda = 1'b1; end
                OP_STOP:     begin n_dir = 1'b1; n_sda = 1'b0; end
                OP_WRITE:    begin
                    n_shift = i_data_byte;
                    n_dir   = 1'b1;
                    n_sda   = i_data_byte[7];
                end
                OP_READ:     begin n_shift = '0; n_dir = 1'b0; end
                OP_SEND_ACK: begin n_dir = 1'b1; n_sda = i_ack_level; end
                default:     begin n_dir = 1'b0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= OP_NONE;
            r_phase    <= 1'b0;
            r_start_ph <= 2'd0;
            r_bit      <= '0;
            r_delay    <= '0;
            r_shift    <= '0;
            r_recv     <= '0;
            r_ack      <= 1'b0;
            r_scl      <= 1'b0;
            r_sda      <= 1'b0;
            r_dir      <= 1'b1;
        end else if (i_step) begin
            r_cmd      <= n_cmd;
            r_phase    <= n_phase;
            r_start_ph <= n_start_ph;
            r_bit      <= n_bit;
            r_delay    <= n_delay;
            r_shift    <= n_shift;
            r_recv     <= n_recv;
            r_ack      <= n_ack;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_dir      <= n_dir;
        end
    end

    always_comb begin
        o_res.scl_level     = n_scl;
        o_res.sda_level     = n_sda;
        o_res.sda_drive     = n_dir;
        o_res.busy_res      = (n_cmd != OP_NONE);
        o_res.done_res      = done;
        o_res.received_byte = n_recv;
        o_res.ack_seen      = n_ack;
    end

endmodule

`default_nettype wire
